### hdl/amfst_pkg.sv
`timescale 1ns / 1ps
package amfst_pkg;

  // defaults
  localparam int MAX_DEPTH_DEF   = 32;
  localparam int DEPTH_LIMIT_RST = 32;

  // byte roles
  localparam logic [3:0] ROLE_MARKER     = 4'd0;
  localparam logic [3:0] ROLE_STRLEN     = 4'd1;
  localparam logic [3:0] ROLE_ARRAYCOUNT = 4'd2;
  localparam logic [3:0] ROLE_ECMACOUNT  = 4'd3;
  localparam logic [3:0] ROLE_F64        = 4'd4;
  localparam logic [3:0] ROLE_TZ         = 4'd5;
  localparam logic [3:0] ROLE_BOOL       = 4'd6;
  localparam logic [3:0] ROLE_STRDATA    = 4'd7;
  localparam logic [3:0] ROLE_NAMELEN    = 4'd8;
  localparam logic [3:0] ROLE_NAME       = 4'd9;
  localparam logic [3:0] ROLE_END        = 4'd10;
  localparam logic [3:0] ROLE_BAD        = 4'd11;

  // value types
  localparam logic [3:0] VT_NUMBER  = 4'd0;
  localparam logic [3:0] VT_BOOL    = 4'd1;
  localparam logic [3:0] VT_STRING  = 4'd2;
  localparam logic [3:0] VT_LONGSTR = 4'd3;
  localparam logic [3:0] VT_OBJECT  = 4'd4;
  localparam logic [3:0] VT_ECMA    = 4'd5;
  localparam logic [3:0] VT_STRICT  = 4'd6;
  localparam logic [3:0] VT_NULL    = 4'd7;
  localparam logic [3:0] VT_UNDEF   = 4'd8;
  localparam logic [3:0] VT_DATE    = 4'd9;
  localparam logic [3:0] VT_NONE    = 4'd10;

  // error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd1;
  localparam logic [2:0] ERR_TOO_DEEP  = 3'd2;
  localparam logic [2:0] ERR_BAD_END   = 3'd3;
  localparam logic [2:0] ERR_TRUNCATED = 3'd4;

  // marker bytes
  localparam logic [7:0] MK_NUMBER  = 8'h00;
  localparam logic [7:0] MK_BOOL    = 8'h01;
  localparam logic [7:0] MK_STRING  = 8'h02;
  localparam logic [7:0] MK_OBJECT  = 8'h03;
  localparam logic [7:0] MK_NULL    = 8'h05;
  localparam logic [7:0] MK_UNDEF   = 8'h06;
  localparam logic [7:0] MK_ECMA    = 8'h08;
  localparam logic [7:0] MK_OBJEND  = 8'h09;
  localparam logic [7:0] MK_STRICT  = 8'h0A;
  localparam logic [7:0] MK_DATE    = 8'h0B;
  localparam logic [7:0] MK_LONGSTR = 8'h0C;

  // frame kinds
  localparam logic [1:0] FK_OBJECT = 2'd0;
  localparam logic [1:0] FK_ECMA   = 2'd1;
  localparam logic [1:0] FK_STRICT = 2'd2;

  typedef enum logic [11:0] {
    PH_MARKER = 12'b0000_0000_0001,
    PH_F64    = 12'b0000_0000_0010,
    PH_TZ     = 12'b0000_0000_0100,
    PH_BOOL   = 12'b0000_0000_1000,
    PH_SLEN   = 12'b0000_0001_0000,
    PH_SDATA  = 12'b0000_0010_0000,
    PH_ACOUNT = 12'b0000_0100_0000,
    PH_ECOUNT = 12'b0000_1000_0000,
    PH_NLEN   = 12'b0001_0000_0000,
    PH_NAME   = 12'b0010_0000_0000,
    PH_END    = 12'b0100_0000_0000,
    PH_DEAD   = 12'b1000_0000_0000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] cnt;
  } frame_t;

  // outcome of one step of closing a finished value
  typedef struct packed {
    logic top;
    logic nlen;
    logic dec;
    logic load;
  } cv_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] byte_role;
    logic [3:0] value_type;
    logic [5:0] nest_level_out;
    logic       top_value_done;
    logic [2:0] error_code;
    logic       buffer_ok;
  } out_word_t;

  // one level of value completion against the top frame
  function automatic cv_t cv_step(logic n_zero, logic n_one, frame_t f);
    cv_t r;
    r = '0;
    if (n_zero) begin
      r.top = 1'b1;
    end else if (f.kind != FK_STRICT) begin
      r.nlen = 1'b1;
    end else if (f.cnt != 32'd1) begin
      r.dec = 1'b1;
    end else if (n_one) begin
      r.top = 1'b1;
    end else begin
      r.load = 1'b1;
    end
    return r;
  endfunction

endpackage

### hdl/amf0_stream_tokenizer.sv
`timescale 1ns / 1ps
// AMF0 byte tokenizer: one byte word in, one labeled word out, one byte per cycle
// sustained while no pop chain or output stall holds input off; each label passes
// through the result stage and the output register. Closing a value pops frames from
// the frame stack RAM one per cycle (one read per cycle, registered read port):
// every pop that leaves the stack non-empty, whether an exhausted strict array or
// the container closed by an object or ECMA end byte, needs a RAM read, and input is
// held off meanwhile. Pops that empty the stack need no read.
// depth_limit is written through cfg_we/cfg_data; the user must write it only while the block is idle (not enforced).
module amf0_stream_tokenizer #(
  parameter int MAX_DEPTH = amfst_pkg::MAX_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [5:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  amfst_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output amfst_pkg::out_word_t out_word
);
  import amfst_pkg::*;

  localparam int DEPTH = MAX_DEPTH + 1;
  localparam int LW    = $clog2(MAX_DEPTH + 2);
  localparam int AW    = $clog2(MAX_DEPTH + 1);

  logic [5:0]    depth_limit;
  phase_t        phase, phase_next;
  logic [3:0]    kind, kind_next;
  logic [3:0]    fidx, fidx_next;
  logic [31:0]   blen, blen_next;
  logic [2:0]    err, err_next;
  logic [LW-1:0] n, n_next;
  frame_t        tos, tos_next;
  logic          loading, loading_next;
  logic          res_valid, res_last;
  out_word_t     res_word;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  frame_t        ram_wdata, ram_rdata;

  logic          in_fire, move;
  logic [3:0]    role, vtype;
  logic [LW-1:0] nest;
  logic          push, cv_go, end_pop, finish, last_src;
  frame_t        push_frame, cv_src;
  cv_t           cvr;
  logic [2:0]    fin_code;
  logic          fin_ok;
  logic [31:0]   blen_sh;
  logic [3:0]    fidx_inc;
  logic [7:0]    lim8, n8;
  logic [3:0]    ctype;
  logic [LW-1:0] cdepth;

  amfst_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake: hold input while a pop chain is reading the stack
  assign move     = res_valid && !loading && (!out_valid || out_ready);
  assign in_ready = !loading && (!res_valid || move);
  assign in_fire  = in_valid && in_ready;

  assign blen_sh  = {blen[23:0], in_word.in_byte};
  assign fidx_inc = fidx + 4'd1;
  assign n8       = 8'(n);
  assign lim8     = (8'(depth_limit) > 8'(MAX_DEPTH)) ? 8'(MAX_DEPTH) : 8'(depth_limit);
  assign ctype    = (n != '0 && tos.kind == FK_ECMA) ? VT_ECMA : VT_OBJECT;
  assign cdepth   = (n != '0) ? n - 1'b1 : '0;

  // decode the byte and update the parse state
  always_comb begin
    phase_next   = phase;
    kind_next    = kind;
    fidx_next    = fidx;
    blen_next    = blen;
    err_next     = err;
    n_next       = n;
    tos_next     = tos;
    loading_next = loading;
    role         = ROLE_BAD;
    vtype        = VT_NONE;
    nest         = '0;
    push         = 1'b0;
    push_frame   = '0;
    cv_go        = 1'b0;
    end_pop      = 1'b0;
    cvr          = '0;
    cv_src       = tos;
    finish       = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = AW'(n - 1'b1);
    ram_wdata    = tos;
    ram_raddr    = '0;
    last_src     = loading ? res_last : in_word.buffer_last;

    if (loading) begin
      // continue the pop chain with the frame just read
      tos_next = ram_rdata;
      cv_src   = ram_rdata;
      cvr      = cv_step(1'b0, n == LW'(1), ram_rdata);
    end else if (in_fire) begin
      case (phase)
        PH_MARKER: begin
          if (n8 > lim8) begin
            if (err == ERR_NONE) err_next = ERR_TOO_DEEP;
            phase_next = PH_DEAD;
          end else begin
            role      = ROLE_MARKER;
            nest      = n;
            fidx_next = '0;
            blen_next = '0;
            case (in_word.in_byte)
              MK_NUMBER:  begin vtype = VT_NUMBER;  phase_next = PH_F64;    end
              MK_BOOL:    begin vtype = VT_BOOL;    phase_next = PH_BOOL;   end
              MK_STRING:  begin vtype = VT_STRING;  phase_next = PH_SLEN;   end
              MK_LONGSTR: begin vtype = VT_LONGSTR; phase_next = PH_SLEN;   end
              MK_OBJECT: begin
                vtype      = VT_OBJECT;
                push       = 1'b1;
                push_frame = '{kind: FK_OBJECT, cnt: 32'd0};
                phase_next = PH_NLEN;
              end
              MK_ECMA:    begin vtype = VT_ECMA;    phase_next = PH_ECOUNT; end
              MK_STRICT:  begin vtype = VT_STRICT;  phase_next = PH_ACOUNT; end
              MK_NULL:    begin vtype = VT_NULL;    cv_go = 1'b1;           end
              MK_UNDEF:   begin vtype = VT_UNDEF;   cv_go = 1'b1;           end
              MK_DATE:    begin vtype = VT_DATE;    phase_next = PH_F64;    end
              default: begin
                role = ROLE_BAD;
                nest = '0;
                if (err == ERR_NONE) err_next = ERR_UNKNOWN;
                phase_next = PH_DEAD;
              end
            endcase
            if (role == ROLE_MARKER) kind_next = vtype;
          end
        end
        PH_F64: begin
          role = ROLE_F64; vtype = kind; nest = n;
          if (fidx_inc >= 4'd8) begin
            fidx_next = '0;
            if (kind == VT_DATE) phase_next = PH_TZ;
            else cv_go = 1'b1;
          end else begin
            fidx_next = fidx_inc;
          end
        end
        PH_TZ: begin
          role = ROLE_TZ; vtype = kind; nest = n;
          fidx_next = fidx_inc;
          if (fidx_inc >= 4'd2) cv_go = 1'b1;
        end
        PH_BOOL: begin
          role = ROLE_BOOL; vtype = kind; nest = n;
          cv_go = 1'b1;
        end
        PH_SLEN: begin
          role = ROLE_STRLEN; vtype = kind; nest = n;
          blen_next = blen_sh;
          fidx_next = fidx_inc;
          if (fidx_inc >= ((kind == VT_LONGSTR) ? 4'd4 : 4'd2)) begin
            if (blen_sh == 32'd0) cv_go = 1'b1;
            else phase_next = PH_SDATA;
          end
        end
        PH_SDATA: begin
          role = ROLE_STRDATA; vtype = kind; nest = n;
          blen_next = blen - 32'd1;
          if (blen_next == 32'd0) cv_go = 1'b1;
        end
        PH_ACOUNT, PH_ECOUNT: begin
          role = (phase == PH_ACOUNT) ? ROLE_ARRAYCOUNT : ROLE_ECMACOUNT;
          vtype = kind; nest = n;
          blen_next = blen_sh;
          fidx_next = fidx_inc;
          if (fidx_inc >= 4'd4) begin
            if (phase == PH_ECOUNT) begin
              push       = 1'b1;
              push_frame = '{kind: FK_ECMA, cnt: 32'd0};
              phase_next = PH_NLEN;
              fidx_next  = '0;
              blen_next  = '0;
            end else if (blen_sh == 32'd0) begin
              cv_go = 1'b1;
            end else begin
              push       = 1'b1;
              push_frame = '{kind: FK_STRICT, cnt: blen_sh};
              phase_next = PH_MARKER;
            end
          end
        end
        PH_NLEN: begin
          role = ROLE_NAMELEN; vtype = ctype; nest = cdepth;
          blen_next = blen_sh;
          fidx_next = fidx_inc;
          if (fidx_inc >= 4'd2) phase_next = (blen_sh == 32'd0) ? PH_END : PH_NAME;
        end
        PH_NAME: begin
          role = ROLE_NAME; vtype = ctype; nest = cdepth;
          blen_next = blen - 32'd1;
          if (blen_next == 32'd0) phase_next = PH_MARKER;
        end
        PH_END: begin
          if (in_word.in_byte != MK_OBJEND) begin
            if (err == ERR_NONE) err_next = ERR_BAD_END;
            phase_next = PH_DEAD;
          end else begin
            role = ROLE_END; vtype = ctype; nest = cdepth;
            end_pop = 1'b1;
          end
        end
        PH_DEAD: begin
          phase_next = PH_DEAD;
        end
        default: begin
          phase_next = PH_DEAD;
        end
      endcase

      // push the new frame, spill the old top to the RAM
      if (push && (n8 < 8'(DEPTH))) begin
        ram_we   = (n != '0);
        tos_next = push_frame;
        n_next   = n + 1'b1;
      end

      // pop the closed container, then finish the value it was part of
      if (end_pop) begin
        if (n <= LW'(1)) cvr.top = 1'b1;
        else cvr.load = 1'b1;
      end else if (cv_go) begin
        cvr = cv_step(n == '0, n == LW'(1), tos);
      end
    end

    // apply the completion step
    if (loading || in_fire) begin
      if (cvr.top) begin
        n_next     = '0;
        phase_next = PH_MARKER;
        kind_next  = VT_NONE;
      end
      if (cvr.nlen) begin
        phase_next = PH_NLEN;
        fidx_next  = '0;
        blen_next  = '0;
      end
      if (cvr.dec) begin
        tos_next.cnt = cv_src.cnt - 32'd1;
        phase_next   = PH_MARKER;
      end
      if (cvr.load) begin
        n_next    = n - 1'b1;
        ram_raddr = AW'(n - LW'(2));
      end
      loading_next = cvr.load;
      finish       = !cvr.load;
    end

    // settle the code and clear on the last byte
    fin_code = err_next;
    if (finish && last_src) begin
      if (err_next == ERR_NONE && !(phase_next == PH_MARKER && n_next == '0)) begin
        fin_code = ERR_TRUNCATED;
      end
      n_next     = '0;
      phase_next = PH_MARKER;
      kind_next  = VT_NONE;
      fidx_next  = '0;
      blen_next  = '0;
      err_next   = ERR_NONE;
    end
    fin_ok = last_src && (fin_code == ERR_NONE);
  end

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_MARKER;
      kind    <= VT_NONE;
      fidx    <= '0;
      blen    <= '0;
      err     <= ERR_NONE;
      n       <= '0;
      loading <= 1'b0;
    end else begin
      phase   <= phase_next;
      kind    <= kind_next;
      fidx    <= fidx_next;
      blen    <= blen_next;
      err     <= err_next;
      n       <= n_next;
      loading <= loading_next;
    end
  end

  always_ff @(posedge clk) begin
    tos <= tos_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_limit <= 6'(DEPTH_LIMIT_RST);
    end else if (cfg_we) begin
      depth_limit <= cfg_data;
    end
  end

  // result stage: fill on accept, finish when the pop chain ends
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_word.out_byte       <= in_word.in_byte;
      res_word.byte_role      <= role;
      res_word.value_type     <= vtype;
      res_word.nest_level_out <= 6'(nest);
      res_word.top_value_done <= cvr.top;
      res_word.error_code     <= fin_code;
      res_word.buffer_ok      <= fin_ok;
      res_last                <= in_word.buffer_last;
    end else if (loading && finish) begin
      res_word.top_value_done <= cvr.top;
      res_word.error_code     <= fin_code;
      res_word.buffer_ok      <= fin_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (in_fire) begin
      res_valid <= 1'b1;
    end else if (move) begin
      res_valid <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (move) begin
      out_word <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### hdl/amfst_ram.sv
`timescale 1ns / 1ps
module amfst_ram #(
  parameter int DEPTH = amfst_pkg::MAX_DEPTH_DEF + 1,
  parameter int AW    = $clog2(amfst_pkg::MAX_DEPTH_DEF + 1)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  amfst_pkg::frame_t    wdata,
  input  logic [AW-1:0]        raddr,
  output amfst_pkg::frame_t    rdata
);
  import amfst_pkg::*;

  frame_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/amfst_chk.sv
`timescale 1ns / 1ps
module amfst_chk (
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input amfst_pkg::out_word_t out_word
);
  import amfst_pkg::*;

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // a clean buffer carries no error
  a_ok_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.buffer_ok |-> out_word.error_code == ERR_NONE)
    else $error("buffer_ok with an error code");

  // bad bytes carry no type and no depth
  a_bad_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.byte_role == ROLE_BAD |->
      out_word.value_type == VT_NONE && out_word.nest_level_out == 6'd0)
    else $error("bad byte with type or depth");

  // a bad byte never completes a value
  a_bad_no_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.byte_role == ROLE_BAD |-> !out_word.top_value_done)
    else $error("bad byte completes a value");

endmodule

bind amf0_stream_tokenizer amfst_chk u_amfst_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);
